// ===== hw/rtl/ptp_pkg.sv =====
package ptp_pkg;

   localparam int ID_BITS        = 6;
   localparam int TIER_BITS      = 2;
   localparam int CSR_INDEX_BITS = 1;

   typedef logic [TIER_BITS-1:0] tier_type;

   localparam tier_type TIER_FAST    = 2'd0;
   localparam tier_type TIER_HOST    = 2'd1;
   localparam tier_type TIER_BACKING = 2'd2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_FAST_BUDGET = 1'd0;
   localparam csr_index_type CSR_HOST_BUDGET = 1'd1;

   typedef enum logic [4:0] {
      ST_LOAD = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_FAST = 5'b00100,
      ST_HOST = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

endpackage

// ===== hw/rtl/ptp_channels.sv =====
interface ptp_req_if #(
   parameter int SIZE_BITS     = 48,
   parameter int PRIORITY_BITS = 8
);
   logic                        valid;
   logic                        ready;
   logic [ptp_pkg::ID_BITS-1:0] entry_id;
   logic [SIZE_BITS-1:0]        size_bytes;
   logic [PRIORITY_BITS-1:0]    priority_req;
   logic                        last_entry;

   modport source (output valid, entry_id, size_bytes, priority_req, last_entry,
                   input ready);
   modport sink (input valid, entry_id, size_bytes, priority_req, last_entry,
                 output ready);
endinterface

interface ptp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ptp_pkg::ID_BITS-1:0] placed_id;
   ptp_pkg::tier_type           tier;
   logic                        last_result;
   logic                        overflowed;

   modport source (output valid, placed_id, tier, last_result, overflowed,
                   input ready);
   modport sink (input valid, placed_id, tier, last_result, overflowed,
                 output ready);
endinterface

// ===== hw/rtl/priority_tier_placement_unit.sv =====
// Loads up to MAX_ENTRIES requests (id, size, priority), one per cycle; a request with
// last_entry set closes the set and starts placement, during which no request is taken.
// Requests past capacity are dropped and flag every result of that run as overflowed.
// Results come out in ascending priority, load order among equal priorities, each one
// placed in the fast tier if it fits the fast budget left, else the host tier if it fits
// the host budget left, else backing. Each result costs a scan of all n stored entries
// through the single table read port, the FAST state and, if the entry does not fit there,
// the HOST state on the shared budget subtractor, and the OUT state holding the result
// until it is taken, so result stalls hold up the rest of the set.
// Budgets written through csr_ are copied in when placement starts.
module priority_tier_placement_unit #(
   parameter int MAX_ENTRIES   = 64,
   parameter int SIZE_BITS     = 48,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ptp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SIZE_BITS-1:0]           csr_wdata,
   ptp_req_if.sink                        req_chan,
   ptp_rsp_if.source                      rsp_chan
);

   localparam int IDX_BITS = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_BITS = PRIORITY_BITS + IDX_BITS;

   typedef struct packed {
      logic [ptp_pkg::ID_BITS-1:0] id;
      logic [SIZE_BITS-1:0]        size;
      logic [PRIORITY_BITS-1:0]    prio;
   } entry_type;

   entry_type mem [MAX_ENTRIES];

   ptp_pkg::state_type state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]  scan_ff, scan_in;
   logic [CNT_BITS-1:0]  done_ff, done_in;
   logic                 rd_vld_ff, rd_vld_in;
   entry_type            rd_data_ff;
   logic [IDX_BITS-1:0]  rd_idx_ff;
   logic                 best_vld_ff, best_vld_in;
   logic [KEY_BITS-1:0]  best_key_ff, best_key_in;
   logic [ptp_pkg::ID_BITS-1:0] best_id_ff, best_id_in;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in;
   logic                 prev_vld_ff, prev_vld_in;
   logic [KEY_BITS-1:0]  prev_key_ff, prev_key_in;
   logic [SIZE_BITS-1:0] fast_budget_ff, host_budget_ff;
   logic [SIZE_BITS-1:0] fast_rem_ff, fast_rem_in;
   logic [SIZE_BITS-1:0] host_rem_ff, host_rem_in;
   ptp_pkg::tier_type    tier_ff, tier_in;

   logic                 req_take, rsp_take, rd_en, mem_we, is_last;
   logic [IDX_BITS-1:0]  rd_addr;
   logic [KEY_BITS-1:0]  rd_key;
   logic [SIZE_BITS:0]   diff;
   logic [SIZE_BITS-1:0] sub_a;

   assign req_chan.ready = (state_ff == ptp_pkg::ST_LOAD);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_chan.valid && rsp_chan.ready;
   assign mem_we         = req_take && (count_ff < CNT_BITS'(MAX_ENTRIES));
   assign rd_en          = (state_ff == ptp_pkg::ST_SCAN) && (scan_ff < count_ff);
   assign rd_addr        = scan_ff[IDX_BITS-1:0];
   assign rd_key         = {rd_data_ff.prio, rd_idx_ff};
   assign is_last        = (done_ff + CNT_BITS'(1)) == count_ff;

   assign sub_a = (state_ff == ptp_pkg::ST_FAST) ? fast_rem_ff : host_rem_ff;
   assign diff  = {1'b0, sub_a} - {1'b0, best_size_ff};

   assign rsp_chan.valid       = (state_ff == ptp_pkg::ST_OUT);
   assign rsp_chan.placed_id   = best_id_ff;
   assign rsp_chan.tier        = tier_ff;
   assign rsp_chan.last_result = is_last;
   assign rsp_chan.overflowed  = ovf_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_BITS-1:0]] <= '{id: req_chan.entry_id,
                                          size: req_chan.size_bytes,
                                          prio: req_chan.priority_req};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      scan_in      = scan_ff;
      done_in      = done_ff;
      rd_vld_in    = 1'b0;
      best_vld_in  = best_vld_ff;
      best_key_in  = best_key_ff;
      best_id_in   = best_id_ff;
      best_size_in = best_size_ff;
      prev_vld_in  = prev_vld_ff;
      prev_key_in  = prev_key_ff;
      fast_rem_in  = fast_rem_ff;
      host_rem_in  = host_rem_ff;
      tier_in      = tier_ff;
      unique case (state_ff)
         ptp_pkg::ST_LOAD: begin
            if (req_take) begin
               if (mem_we) begin
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last_entry) begin
                  state_in    = ptp_pkg::ST_SCAN;
                  fast_rem_in = fast_budget_ff;
                  host_rem_in = host_budget_ff;
                  done_in     = '0;
                  prev_vld_in = 1'b0;
                  scan_in     = '0;
                  best_vld_in = 1'b0;
               end
            end
         end
         ptp_pkg::ST_SCAN: begin
            if (rd_en) begin
               scan_in   = scan_ff + CNT_BITS'(1);
               rd_vld_in = 1'b1;
            end else if (!rd_vld_ff) begin
               state_in = ptp_pkg::ST_FAST;
            end
            if (rd_vld_ff && (!prev_vld_ff || rd_key > prev_key_ff)
                && (!best_vld_ff || rd_key < best_key_ff)) begin
               best_vld_in  = 1'b1;
               best_key_in  = rd_key;
               best_id_in   = rd_data_ff.id;
               best_size_in = rd_data_ff.size;
            end
         end
         ptp_pkg::ST_FAST: begin
            if (!diff[SIZE_BITS]) begin
               fast_rem_in = diff[SIZE_BITS-1:0];
               tier_in     = ptp_pkg::TIER_FAST;
               state_in    = ptp_pkg::ST_OUT;
            end else begin
               state_in = ptp_pkg::ST_HOST;
            end
         end
         ptp_pkg::ST_HOST: begin
            if (!diff[SIZE_BITS]) begin
               host_rem_in = diff[SIZE_BITS-1:0];
               tier_in     = ptp_pkg::TIER_HOST;
            end else begin
               tier_in = ptp_pkg::TIER_BACKING;
            end
            state_in = ptp_pkg::ST_OUT;
         end
         ptp_pkg::ST_OUT: begin
            if (rsp_take) begin
               prev_vld_in = 1'b1;
               prev_key_in = best_key_ff;
               done_in     = done_ff + CNT_BITS'(1);
               if (is_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ptp_pkg::ST_LOAD;
               end else begin
                  scan_in     = '0;
                  best_vld_in = 1'b0;
                  state_in    = ptp_pkg::ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ptp_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ptp_pkg::ST_LOAD;
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         rd_vld_ff      <= 1'b0;
         best_vld_ff    <= 1'b0;
         prev_vld_ff    <= 1'b0;
         fast_budget_ff <= '0;
         host_budget_ff <= '0;
         fast_rem_ff    <= '0;
         host_rem_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         rd_vld_ff   <= rd_vld_in;
         best_vld_ff <= best_vld_in;
         prev_vld_ff <= prev_vld_in;
         fast_rem_ff <= fast_rem_in;
         host_rem_ff <= host_rem_in;
         if (csr_we && csr_index == ptp_pkg::CSR_FAST_BUDGET) begin
            fast_budget_ff <= csr_wdata;
         end
         if (csr_we && csr_index == ptp_pkg::CSR_HOST_BUDGET) begin
            host_budget_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_in_hold: begin
         scan_ff      <= scan_in;
         done_ff      <= done_in;
         best_key_ff  <= best_key_in;
         best_id_ff   <= best_id_in;
         best_size_ff <= best_size_in;
         prev_key_ff  <= prev_key_in;
         tier_ff      <= tier_in;
      end
   end

   a_ready_xor_valid: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a result is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_ENTRIES))
      else $error("entry count beyond capacity");

   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (done_ff < count_ff) && best_vld_ff)
      else $error("result without a selected entry");

   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && is_last) |=> (count_ff == '0) && !ovf_ff && req_chan.ready)
      else $error("run state not cleared after final result");

endmodule

// ===== tb/priority_tier_placement_unit_tb.sv =====
`timescale 1ns / 1ps

module priority_tier_placement_unit_tb;

   localparam int MAX_ENTRIES      = 64;
   localparam int SIZE_BITS        = 48;
   localparam int PRIORITY_BITS    = 8;
   localparam int CYCLE_LIMIT      = 500000;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES    = 16;
   localparam int RANDOM_REQUESTS  = 310;
   localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

   typedef struct {
      logic [ptp_pkg::ID_BITS-1:0] entry_id;
      logic [SIZE_BITS-1:0]        size_bytes;
      logic [PRIORITY_BITS-1:0]    priority_req;
      logic                        last_entry;
   } entry_request_type;

   typedef struct {
      logic [ptp_pkg::ID_BITS-1:0] placed_id;
      ptp_pkg::tier_type           tier;
      logic                        last_result;
      logic                        overflowed;
   } placement_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   ptp_pkg::csr_index_type csr_index;
   logic [SIZE_BITS-1:0]   csr_wdata;

   ptp_req_if #(.SIZE_BITS(SIZE_BITS), .PRIORITY_BITS(PRIORITY_BITS)) req_chan ();
   ptp_rsp_if rsp_chan ();

   priority_tier_placement_unit #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .SIZE_BITS    (SIZE_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   entry_request_type    pending_requests[$];
   placement_type        placements_due[$];
   entry_request_type    loaded_entries[MAX_ENTRIES];
   int                   loaded_count = 0;
   bit                   dropped_entry = 1'b0;
   logic [SIZE_BITS-1:0] fast_budget_cfg = '0;
   logic [SIZE_BITS-1:0] host_budget_cfg = '0;
   int                   error_count = 0;
   int                   request_total = 0;
   int                   cycle_count = 0;
   bit                   sender_idles = 1'b1;
   bit                   receiver_idles = 1'b1;
   bit                   long_hold_armed = 1'b0;

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.entry_id     = '0;
      req_chan.size_bytes   = '0;
      req_chan.priority_req = '0;
      req_chan.last_entry   = 1'b0;
      rsp_chan.ready        = 1'b0;
      csr_we                = 1'b0;
      csr_index             = ptp_pkg::CSR_FAST_BUDGET;
      csr_wdata             = '0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   // sort by priority, keep load order on ties, then fill fast, host, backing
   task automatic place_loaded_entries();
      int                   order[MAX_ENTRIES];
      int                   k;
      logic [SIZE_BITS-1:0] fast_left;
      logic [SIZE_BITS-1:0] host_left;
      entry_request_type    e;
      placement_type        p;
      for (int i = 0; i < loaded_count; i++) begin
         k = i;
         while (k > 0 && loaded_entries[order[k-1]].priority_req >
                         loaded_entries[i].priority_req) begin
            order[k] = order[k-1];
            k--;
         end
         order[k] = i;
      end
      fast_left = fast_budget_cfg;
      host_left = host_budget_cfg;
      for (int i = 0; i < loaded_count; i++) begin
         e = loaded_entries[order[i]];
         if (e.size_bytes <= fast_left) begin
            p.tier = ptp_pkg::TIER_FAST;
            fast_left -= e.size_bytes;
         end else if (e.size_bytes <= host_left) begin
            p.tier = ptp_pkg::TIER_HOST;
            host_left -= e.size_bytes;
         end else begin
            p.tier = ptp_pkg::TIER_BACKING;
         end
         p.placed_id   = e.entry_id;
         p.last_result = (i == loaded_count - 1);
         p.overflowed  = dropped_entry;
         placements_due.insert(placements_due.size(), p);
      end
      loaded_count  = 0;
      dropped_entry = 1'b0;
   endtask

   task automatic take_request(input entry_request_type r);
      if (loaded_count < MAX_ENTRIES) begin
         loaded_entries[loaded_count] = r;
         loaded_count++;
      end else begin
         dropped_entry = 1'b1;
      end
      if (r.last_entry) place_loaded_entries();
   endtask

   task automatic present_next_request();
      req_chan.valid        <= 1'b1;
      req_chan.entry_id     <= pending_requests[0].entry_id;
      req_chan.size_bytes   <= pending_requests[0].size_bytes;
      req_chan.priority_req <= pending_requests[0].priority_req;
      req_chan.last_entry   <= pending_requests[0].last_entry;
   endtask

   int send_gap = 0;

   always @(posedge clock) begin : request_driver
      entry_request_type accepted;
      int                gap;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else if (req_chan.valid && req_chan.ready) begin
         accepted.entry_id     = req_chan.entry_id;
         accepted.size_bytes   = req_chan.size_bytes;
         accepted.priority_req = req_chan.priority_req;
         accepted.last_entry   = req_chan.last_entry;
         void'(pending_requests.pop_front());
         take_request(accepted);
         gap = sender_idles ? pick_gap() : 0;
         if (gap == 0 && pending_requests.size() != 0) begin
            present_next_request();
         end else begin
            req_chan.valid <= 1'b0;
            send_gap       <= gap;
         end
      end else if (!req_chan.valid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_requests.size() != 0) begin
            present_next_request();
         end
      end
   end

   int hold_left = 0;
   bit long_hold_taken = 1'b0;

   always @(posedge clock) begin : response_pacer
      if (reset) begin
         rsp_chan.ready  <= 1'b0;
         hold_left       <= 0;
         long_hold_taken <= 1'b0;
      end else if (long_hold_armed && !long_hold_taken && rsp_chan.valid) begin
         rsp_chan.ready  <= 1'b0;
         hold_left       <= LONG_HOLD_CYCLES;
         long_hold_taken <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= pick_gap();
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : placement_monitor
      placement_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (placements_due.size() == 0) begin
            report_mismatch($sformatf("unexpected placement of id %0d", rsp_chan.placed_id));
         end else begin
            want = placements_due.pop_front();
            if (rsp_chan.placed_id !== want.placed_id || rsp_chan.tier !== want.tier ||
                rsp_chan.last_result !== want.last_result ||
                rsp_chan.overflowed !== want.overflowed) begin
               report_mismatch($sformatf(
                  "got id %0d tier %0d last %b ovf %b, want id %0d tier %0d last %b ovf %b",
                  rsp_chan.placed_id, rsp_chan.tier, rsp_chan.last_result,
                  rsp_chan.overflowed, want.placed_id, want.tier, want.last_result,
                  want.overflowed));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("priority_tier_placement_unit_tb failed");
         $finish;
      end
   end

   task automatic write_budget(input ptp_pkg::csr_index_type index,
                               input logic [SIZE_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == ptp_pkg::CSR_FAST_BUDGET) fast_budget_cfg = value;
      else host_budget_cfg = value;
   endtask

   task automatic set_budgets(input logic [SIZE_BITS-1:0] fast,
                              input logic [SIZE_BITS-1:0] host);
      write_budget(ptp_pkg::CSR_FAST_BUDGET, fast);
      write_budget(ptp_pkg::CSR_HOST_BUDGET, host);
      @(negedge clock);
   endtask

   task automatic queue_request(input logic [ptp_pkg::ID_BITS-1:0] id,
                                input logic [SIZE_BITS-1:0] size,
                                input logic [PRIORITY_BITS-1:0] prio, input logic last);
      entry_request_type r;
      r.entry_id     = id;
      r.size_bytes   = size;
      r.priority_req = prio;
      r.last_entry   = last;
      pending_requests.insert(pending_requests.size(), r);
      request_total++;
   endtask

   // hold until every request is taken and every placement has come back
   task automatic drain();
      while (pending_requests.size() != 0 || req_chan.valid || placements_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SIZE_BITS-1:0] rand_budget();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: return '0;
         1: return SIZE_MAX;
         2: return SIZE_BITS'($urandom_range(1, 4000));
         3: return wide[SIZE_BITS-1:0];
         default: return {16'h0, wide[31:0]};
      endcase
   endfunction

   function automatic logic [SIZE_BITS-1:0] rand_size();
      logic [63:0] wide;
      logic [63:0] span;
      wide = {$urandom, $urandom};
      span = 64'((fast_budget_cfg > host_budget_cfg) ? fast_budget_cfg : host_budget_cfg);
      span = span / 3 + 1;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return SIZE_MAX;
         2: return wide[SIZE_BITS-1:0];
         3: return 1;
         default: return SIZE_BITS'(wide % span);
      endcase
   endfunction

   task automatic queue_random_set(input int entries);
      bit tie_heavy;
      tie_heavy = 1'($urandom_range(0, 1));
      for (int i = 0; i < entries; i++)
         queue_request(ptp_pkg::ID_BITS'($urandom_range(0, 63)), rand_size(),
                       tie_heavy ? PRIORITY_BITS'($urandom_range(0, 3))
                                 : PRIORITY_BITS'($urandom_range(0, 255)),
                       i == entries - 1);
   endtask

   initial begin : stimulus
      int random_stop;
      int phase_no;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // no budget at all, duplicate ids, single entry set
      set_budgets('0, '0);
      queue_request(0, '0, 255, 1'b0);
      queue_request(63, 1, 0, 1'b0);
      queue_request(63, SIZE_MAX, 0, 1'b1);
      queue_request(21, '0, 128, 1'b1);
      drain();

      // full budgets, equal priorities keep load order
      set_budgets(SIZE_MAX, SIZE_MAX);
      queue_request(1, SIZE_MAX, 7, 1'b0);
      queue_request(2, SIZE_MAX, 7, 1'b0);
      queue_request(3, SIZE_MAX, 7, 1'b0);
      queue_request(4, '0, 7, 1'b1);
      queue_request(10, 48'h5555_5555_5555, 5, 1'b0);
      queue_request(11, 48'haaaa_aaaa_aaaa, 3, 1'b0);
      queue_request(12, 48'h0000_ffff_0000, 5, 1'b0);
      queue_request(13, 3, 0, 1'b0);
      queue_request(14, 9, 3, 1'b0);
      queue_request(15, 48'h8000_0000_0000, 255, 1'b0);
      queue_request(16, 17, 0, 1'b0);
      queue_request(17, 1, 5, 1'b1);
      drain();

      // exact fits against both budgets
      set_budgets(100, 50);
      queue_request(40, 60, 1, 1'b0);
      queue_request(41, 40, 1, 1'b0);
      queue_request(42, 50, 2, 1'b0);
      queue_request(43, 1, 3, 1'b1);
      drain();

      set_budgets('0, SIZE_MAX);
      queue_request(5, SIZE_MAX, 1, 1'b0);
      queue_request(6, 48'h8000_0000_0000, 0, 1'b0);
      queue_request(7, 48'h5555_5555_5555, 2, 1'b1);
      drain();

      random_stop = request_total + RANDOM_REQUESTS;
      phase_no = 0;
      while (request_total < random_stop) begin
         set_budgets(rand_budget(), rand_budget());
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         if (phase_no == 2) begin
            long_hold_armed = 1'b1;
            queue_random_set(MAX_ENTRIES);
            repeat (3) queue_random_set($urandom_range(1, 6));
         end else if (phase_no == 5) begin
            queue_random_set(MAX_ENTRIES + $urandom_range(1, 3));
         end else begin
            repeat ($urandom_range(2, 5)) queue_random_set($urandom_range(1, 10));
         end
         drain();
         phase_no++;
      end

      if (error_count == 0) begin
         $display("priority_tier_placement_unit_tb passed");
      end else begin
         $display("priority_tier_placement_unit_tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ptp_pkg.sv
hw/rtl/ptp_channels.sv
hw/rtl/priority_tier_placement_unit.sv
tb/priority_tier_placement_unit_tb.sv
